// ===== rtl/e1fah_pkg.sv =====
// e1fah_pkg: constants, register indexes and shared types for the e1 frame alignment hunt
// no dependencies; imported by e1fah_align and e1_frame_alignment_hunt
`timescale 1ns / 1ps

package e1fah_pkg;

    localparam int WORDS_PER_BUFFER = 256;
    localparam int BUFFERS          = 4;
    localparam int FRAME_BITS       = 256;

    localparam int WORD_W       = 32;
    localparam int OCTET_W      = 8;
    localparam int FAS_W        = 7;
    localparam int OFFSET_W     = $clog2(FRAME_BITS);
    localparam int WCNT_W       = $clog2(WORDS_PER_BUFFER);
    localparam int BUF_W        = (BUFFERS > 1) ? $clog2(BUFFERS) : 1;
    localparam int CHECK_STRIDE = FRAME_BITS / 16;
    localparam int STRIDE_W     = $clog2(CHECK_STRIDE);
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 8;

    localparam logic [WCNT_W-1:0] LAST_WORD   = WCNT_W'(WORDS_PER_BUFFER - 1);
    localparam logic [WCNT_W-1:0] HALF_WORD   = WCNT_W'(WORDS_PER_BUFFER / 2);
    localparam logic [BUF_W-1:0]  LAST_BUFFER = BUF_W'(BUFFERS - 1);
    localparam logic [OFFSET_W:0] OFFSET_WRAP = (OFFSET_W + 1)'(FRAME_BITS);

    localparam logic [CFG_IDX_W-1:0] REG_START_OFFSET = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FAS_VALUE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FAS_MASK     = 2'd2;

    localparam logic [OFFSET_W-1:0] START_OFFSET_RST = OFFSET_W'(16);
    localparam logic [FAS_W-1:0]    FAS_VALUE_RST    = 7'h1b;
    localparam logic [FAS_W-1:0]    FAS_MASK_RST     = 7'h7f;

    typedef struct packed {
        logic [FAS_W-1:0] fas_value;
        logic [FAS_W-1:0] fas_mask;
    } e1fah_fas_cfg_t;

    typedef struct packed {
        logic                load;
        logic [OFFSET_W-1:0] value;
    } e1fah_offset_load_t;

    typedef struct packed {
        logic                buffer_end;
        logic                slip;
        logic                restart;
        logic [OFFSET_W-1:0] frame_offset;
    } e1fah_status_t;

    function automatic logic [WORD_W-1:0] byte_swap(input logic [WORD_W-1:0] w);
        byte_swap = {w[7:0], w[15:8], w[23:16], w[31:24]};
    endfunction

endpackage

// ===== rtl/e1_frame_alignment_hunt.sv =====
// e1_frame_alignment_hunt: top level with config registers, output register and checks
// depends on e1fah_pkg and e1fah_align
`timescale 1ns / 1ps

// Takes one received E1 word per request and returns it byte-reversed together with the
// buffer end flag, slip and restart flags and the frame pulse offset after that word.
// Words are counted in buffers of 256, buffers modulo 4; in buffer 0 the TS0 octet of
// every second frame in the second half is checked against the masked FAS value, and a
// mismatch advances the offset by one on the buffer's last word (255 wraps to 1 with
// restart). A request is accepted every cycle unless a result waits with m_ready low;
// its result enters the output register in the cycle after. Writing start_offset also
// reloads the current offset; write registers only idle.

module e1_frame_alignment_hunt
    import e1fah_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [WORD_W-1:0]     s_rx_word,

    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [WORD_W-1:0]     m_swapped_word,
    output logic                  m_buffer_end,
    output logic                  m_slip,
    output logic                  m_restart,
    output logic [OFFSET_W-1:0]   m_frame_offset
);

    logic [FAS_W-1:0]    fas_value_reg;
    logic [FAS_W-1:0]    fas_mask_reg;
    logic                m_valid_reg;
    logic                m_valid_next;
    logic [WORD_W-1:0]   swapped_reg;
    e1fah_status_t       status_reg;

    logic                accept;
    e1fah_fas_cfg_t      fas_cfg;
    e1fah_offset_load_t  offset_load;
    e1fah_status_t       status;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    assign fas_cfg.fas_value = fas_value_reg;
    assign fas_cfg.fas_mask  = fas_mask_reg;
    assign offset_load.load  = cfg_wr_en && (cfg_index == REG_START_OFFSET);
    assign offset_load.value = cfg_wdata[OFFSET_W-1:0];

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fas_value_reg <= FAS_VALUE_RST;
            fas_mask_reg  <= FAS_MASK_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_FAS_VALUE: fas_value_reg <= cfg_wdata[FAS_W-1:0];
                REG_FAS_MASK:  fas_mask_reg  <= cfg_wdata[FAS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    e1fah_align u_align (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (accept),
        .ts0         (s_rx_word[WORD_W-1 -: OCTET_W]),
        .fas_cfg     (fas_cfg),
        .offset_load (offset_load),
        .status      (status)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        if (accept) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            swapped_reg <= byte_swap(s_rx_word);
            status_reg  <= status;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_swapped_word = swapped_reg;
    assign m_buffer_end   = status_reg.buffer_end;
    assign m_slip         = status_reg.slip;
    assign m_restart      = status_reg.restart;
    assign m_frame_offset = status_reg.frame_offset;

    a_restart_needs_slip: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_restart |-> m_slip)
        else $error("restart without slip");

    a_slip_on_buffer_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_slip |-> m_buffer_end)
        else $error("slip away from buffer end");

    a_slip_offset_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_slip |-> m_frame_offset != '0)
        else $error("zero offset after slip");

    a_result_follows_request: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> m_valid)
        else $error("accepted request produced no result");

endmodule

// ===== rtl/e1fah_align.sv =====
// e1fah_align: word and buffer counters, fas check latch and frame pulse offset tracking
// depends on e1fah_pkg
`timescale 1ns / 1ps

module e1fah_align
    import e1fah_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step,
    input  logic [OCTET_W-1:0]  ts0,
    input  e1fah_fas_cfg_t      fas_cfg,
    input  e1fah_offset_load_t  offset_load,
    output e1fah_status_t       status
);

    logic [WCNT_W-1:0]   word_count_reg;
    logic [WCNT_W-1:0]   word_count_next;
    logic [BUF_W-1:0]    buffer_index_reg;
    logic [BUF_W-1:0]    buffer_index_next;
    logic                fas_failed_reg;
    logic                fas_failed_next;
    logic [OFFSET_W-1:0] pulse_offset_reg;
    logic [OFFSET_W-1:0] pulse_offset_next;

    logic                last_word;
    logic                check_word;
    logic                mismatch;
    logic                failed_any;
    logic [OFFSET_W:0]   offset_inc;
    logic                slip;
    logic                restart;

    assign last_word  = (word_count_reg == LAST_WORD);
    assign check_word = (buffer_index_reg == '0) && (word_count_reg >= HALF_WORD)
                        && (word_count_reg[STRIDE_W-1:0] == '0);
    assign mismatch   = (ts0[FAS_W-1:0] & fas_cfg.fas_mask)
                        != (fas_cfg.fas_value & fas_cfg.fas_mask);
    assign failed_any = fas_failed_reg || (check_word && mismatch);
    assign offset_inc = {1'b0, pulse_offset_reg} + (OFFSET_W + 1)'(1);
    assign slip       = last_word && (buffer_index_reg == '0) && failed_any;
    assign restart    = slip && (offset_inc >= OFFSET_WRAP);

    always_comb begin
        word_count_next   = word_count_reg;
        buffer_index_next = buffer_index_reg;
        fas_failed_next   = fas_failed_reg;
        pulse_offset_next = pulse_offset_reg;
        if (step) begin
            if (last_word) begin
                word_count_next   = '0;
                fas_failed_next   = 1'b0;
                buffer_index_next = (buffer_index_reg == LAST_BUFFER) ? '0
                                    : buffer_index_reg + BUF_W'(1);
                if (restart) begin
                    pulse_offset_next = OFFSET_W'(1);
                end else if (slip) begin
                    pulse_offset_next = offset_inc[OFFSET_W-1:0];
                end
            end else begin
                word_count_next = word_count_reg + WCNT_W'(1);
                fas_failed_next = failed_any;
            end
        end
        if (offset_load.load) begin
            pulse_offset_next = offset_load.value;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            word_count_reg   <= '0;
            buffer_index_reg <= '0;
            fas_failed_reg   <= 1'b0;
            pulse_offset_reg <= START_OFFSET_RST;
        end else begin
            word_count_reg   <= word_count_next;
            buffer_index_reg <= buffer_index_next;
            fas_failed_reg   <= fas_failed_next;
            pulse_offset_reg <= pulse_offset_next;
        end
    end

    // status of the current request, offset as it stands after this word
    always_comb begin
        status.buffer_end   = last_word;
        status.slip         = slip;
        status.restart      = restart;
        status.frame_offset = restart ? OFFSET_W'(1)
                              : (slip ? offset_inc[OFFSET_W-1:0] : pulse_offset_reg);
    end

endmodule
